FILE: rtl/core/rcf_pkg.sv
`timescale 1ns / 1ps

package rcf_pkg;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic [1:0]  FMT_TYPE0 = 2'd0;
  localparam logic [1:0]  FMT_TYPE1 = 2'd1;
  localparam logic [1:0]  FMT_TYPE3 = 2'd3;

  localparam logic [23:0] CHUNK_CAP_RESET  = 24'd128;
  localparam logic [23:0] EXT_TS_MARK      = 24'hffffff;
  localparam logic [16:0] LONG_ID_BASE     = 17'd64;
  localparam logic [16:0] TWO_BYTE_LIMIT   = 17'd320;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // byte slots of one command, in wire order
  localparam int S_B0  = 0;
  localparam int S_B1  = 1;
  localparam int S_B2  = 2;
  localparam int S_T0  = 3;
  localparam int S_T1  = 4;
  localparam int S_T2  = 5;
  localparam int S_L0  = 6;
  localparam int S_L1  = 7;
  localparam int S_L2  = 8;
  localparam int S_TID = 9;
  localparam int S_S0  = 10;
  localparam int S_S1  = 11;
  localparam int S_S2  = 12;
  localparam int S_S3  = 13;
  localparam int S_E0  = 14;
  localparam int S_E1  = 15;
  localparam int S_E2  = 16;
  localparam int S_E3  = 17;
  localparam int S_P   = 18;
  localparam int NUM_SLOTS = 19;

  typedef struct packed {
    logic        has_basic;
    logic        has_ts;
    logic        has_len;
    logic        has_sid;
    logic        has_ext;
    logic        has_pay;
    logic        done;
    logic [1:0]  fmt;
    logic [16:0] csid;
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  tid;
    logic [31:0] sid;
    logic [7:0]  pb;
  } cmd_t;

endpackage

FILE: rtl/core/rcf_front.sv
`timescale 1ns / 1ps

module rcf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data,
  input  logic               accept_i,
  input  logic               operation_i,
  input  logic [1:0]         format_type_i,
  input  logic [16:0]        chunk_stream_id_i,
  input  logic [31:0]        timestamp_i,
  input  logic               extended_i,
  input  logic [23:0]        message_length_i,
  input  logic [7:0]         type_id_i,
  input  logic [31:0]        stream_id_i,
  input  logic [7:0]         payload_byte_i,
  output logic               push_o,
  output rcf_pkg::cmd_t      cmd_o
);

  logic [23:0] chunk_cap_r;
  logic [23:0] bytes_in_chunk_r, bytes_in_chunk_nxt;
  logic [23:0] bytes_left_r, bytes_left_nxt;
  logic [16:0] held_csid_r;
  logic        held_ext_r;
  logic [31:0] held_ts_r;
  logic        boundary;
  logic        is_hdr;

  assign is_hdr   = (operation_i == rcf_pkg::OP_HEADER);
  assign boundary = (chunk_cap_r != 24'd0) && (bytes_in_chunk_r >= chunk_cap_r);

  always_comb begin
    cmd_o              = '0;
    push_o             = 1'b0;
    bytes_in_chunk_nxt = bytes_in_chunk_r;
    bytes_left_nxt     = bytes_left_r;
    if (is_hdr) begin
      push_o             = accept_i && (message_length_i != 24'd0);
      bytes_in_chunk_nxt = 24'd0;
      bytes_left_nxt     = message_length_i;
      cmd_o.has_basic    = 1'b1;
      cmd_o.has_ts       = (format_type_i != rcf_pkg::FMT_TYPE3);
      cmd_o.has_len      = (format_type_i == rcf_pkg::FMT_TYPE0) ||
                           (format_type_i == rcf_pkg::FMT_TYPE1);
      cmd_o.has_sid      = (format_type_i == rcf_pkg::FMT_TYPE0);
      cmd_o.has_ext      = extended_i;
      cmd_o.fmt          = format_type_i;
      cmd_o.csid         = chunk_stream_id_i;
      cmd_o.ts           = timestamp_i;
      cmd_o.len          = message_length_i;
      cmd_o.tid          = type_id_i;
      cmd_o.sid          = stream_id_i;
    end else begin
      push_o          = accept_i && (bytes_left_r != 24'd0);
      cmd_o.has_basic = boundary;
      cmd_o.has_ext   = boundary && held_ext_r;
      cmd_o.has_pay   = 1'b1;
      cmd_o.done      = (bytes_left_r == 24'd1);
      cmd_o.fmt       = rcf_pkg::FMT_TYPE3;
      cmd_o.csid      = held_csid_r;
      cmd_o.ts        = held_ts_r;
      cmd_o.pb        = payload_byte_i;
      if (bytes_left_r != 24'd0) begin
        bytes_left_nxt     = bytes_left_r - 24'd1;
        bytes_in_chunk_nxt = boundary ? 24'd1 : bytes_in_chunk_r + 24'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_cap_r      <= rcf_pkg::CHUNK_CAP_RESET;
      bytes_in_chunk_r <= '0;
      bytes_left_r     <= '0;
      held_csid_r      <= '0;
      held_ext_r       <= 1'b0;
      held_ts_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        chunk_cap_r <= cfg_wr_data;
      end
      if (accept_i) begin
        bytes_in_chunk_r <= bytes_in_chunk_nxt;
        bytes_left_r     <= bytes_left_nxt;
        if (is_hdr) begin
          held_csid_r <= chunk_stream_id_i;
          held_ext_r  <= extended_i;
          held_ts_r   <= timestamp_i;
        end
      end
    end
  end

endmodule

FILE: rtl/core/rcf_cmd_queue.sv
`timescale 1ns / 1ps

module rcf_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  rcf_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output rcf_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);

  rcf_pkg::cmd_t mem_r [rcf_pkg::CMD_DEPTH];
  logic [rcf_pkg::CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [rcf_pkg::CMD_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == rcf_pkg::CMD_CNT_W'(rcf_pkg::CMD_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o))
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && empty_o))
    else $error("command popped from empty queue");

endmodule

FILE: rtl/core/rcf_back.sv
`timescale 1ns / 1ps

module rcf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rcf_pkg::cmd_t head_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  input  logic          out_pop,
  output logic          out_empty,
  output logic [7:0]    out_byte,
  output logic          out_run_last,
  output logic          out_message_done
);

  localparam int NS = rcf_pkg::NUM_SLOTS;

  logic [NS-1:0] sent_r, sent_nxt;
  logic [NS-1:0] mask, active, pick, rest;
  logic [7:0]    slot_b [NS];
  logic [7:0]    sel_byte;
  logic [16:0]   id_m64;
  logic [23:0]   ts24;
  logic [5:0]    id_low;
  logic          long_id, very_long_id;
  logic          load, last, out_take;
  logic          out_valid_r;
  logic [7:0]    byte_r;
  logic          run_last_r, done_r;

  assign id_m64       = head_i.csid - rcf_pkg::LONG_ID_BASE;
  assign long_id      = (head_i.csid >= rcf_pkg::LONG_ID_BASE);
  assign very_long_id = (head_i.csid >= rcf_pkg::TWO_BYTE_LIMIT);
  assign ts24         = head_i.has_ext ? rcf_pkg::EXT_TS_MARK : head_i.ts[23:0];
  assign id_low       = !long_id ? head_i.csid[5:0] : (very_long_id ? 6'd1 : 6'd0);

  always_comb begin
    mask                   = '0;
    mask[rcf_pkg::S_B0]    = head_i.has_basic;
    mask[rcf_pkg::S_B1]    = head_i.has_basic && long_id;
    mask[rcf_pkg::S_B2]    = head_i.has_basic && very_long_id;
    mask[rcf_pkg::S_T0]    = head_i.has_ts;
    mask[rcf_pkg::S_T1]    = head_i.has_ts;
    mask[rcf_pkg::S_T2]    = head_i.has_ts;
    mask[rcf_pkg::S_L0]    = head_i.has_len;
    mask[rcf_pkg::S_L1]    = head_i.has_len;
    mask[rcf_pkg::S_L2]    = head_i.has_len;
    mask[rcf_pkg::S_TID]   = head_i.has_len;
    mask[rcf_pkg::S_S0]    = head_i.has_sid;
    mask[rcf_pkg::S_S1]    = head_i.has_sid;
    mask[rcf_pkg::S_S2]    = head_i.has_sid;
    mask[rcf_pkg::S_S3]    = head_i.has_sid;
    mask[rcf_pkg::S_E0]    = head_i.has_ext;
    mask[rcf_pkg::S_E1]    = head_i.has_ext;
    mask[rcf_pkg::S_E2]    = head_i.has_ext;
    mask[rcf_pkg::S_E3]    = head_i.has_ext;
    mask[rcf_pkg::S_P]     = head_i.has_pay;

    slot_b[rcf_pkg::S_B0]  = {head_i.fmt, id_low};
    slot_b[rcf_pkg::S_B1]  = id_m64[7:0];
    slot_b[rcf_pkg::S_B2]  = id_m64[15:8];
    slot_b[rcf_pkg::S_T0]  = ts24[23:16];
    slot_b[rcf_pkg::S_T1]  = ts24[15:8];
    slot_b[rcf_pkg::S_T2]  = ts24[7:0];
    slot_b[rcf_pkg::S_L0]  = head_i.len[23:16];
    slot_b[rcf_pkg::S_L1]  = head_i.len[15:8];
    slot_b[rcf_pkg::S_L2]  = head_i.len[7:0];
    slot_b[rcf_pkg::S_TID] = head_i.tid;
    slot_b[rcf_pkg::S_S0]  = head_i.sid[7:0];
    slot_b[rcf_pkg::S_S1]  = head_i.sid[15:8];
    slot_b[rcf_pkg::S_S2]  = head_i.sid[23:16];
    slot_b[rcf_pkg::S_S3]  = head_i.sid[31:24];
    slot_b[rcf_pkg::S_E0]  = head_i.ts[31:24];
    slot_b[rcf_pkg::S_E1]  = head_i.ts[23:16];
    slot_b[rcf_pkg::S_E2]  = head_i.ts[15:8];
    slot_b[rcf_pkg::S_E3]  = head_i.ts[7:0];
    slot_b[rcf_pkg::S_P]   = head_i.pb;
  end

  // next slot of the head command still to be sent
  assign active = q_empty_i ? '0 : (mask & ~sent_r);
  assign pick   = active & (~active + 1'b1);
  assign rest   = active & ~pick;
  assign last   = (rest == '0);

  always_comb begin
    sel_byte = 8'd0;
    for (int i = 0; i < NS; i++) begin
      sel_byte = sel_byte | (slot_b[i] & {8{pick[i]}});
    end
  end

  assign out_take = out_pop && out_valid_r;
  assign load     = (active != '0) && (!out_valid_r || out_pop);
  assign q_pop_o  = load && last;

  always_comb begin
    sent_nxt = sent_r;
    if (load) begin
      sent_nxt = last ? '0 : (sent_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= sel_byte;
      run_last_r <= last;
      done_r     <= pick[rcf_pkg::S_P] && head_i.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r <= sent_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_byte         = byte_r;
  assign out_run_last     = run_last_r;
  assign out_message_done = done_r;

  a_partial_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
    (sent_r != '0) |-> !q_empty_i)
    else $error("command left the queue before all its bytes were sent");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> run_last_r)
    else $error("message end not on the last byte of a transaction");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> ($stable(byte_r) && out_valid_r))
    else $error("output byte overwritten while stalled");

endmodule

FILE: rtl/core/rtmp_chunk_framer_unit.sv
`timescale 1ns / 1ps
// rtmp chunk framer
// input queue side: present an item and raise in_push; it is taken on a clock
//   edge with in_full low. operation 0 opens a message (basic header plus type
//   0 to 3 message header, extended timestamp when in_extended is set),
//   operation 1 carries one payload byte. a zero length header or a payload
//   byte with no bytes left produces nothing.
// output queue side: while out_empty is low, out_byte is the oldest waiting
//   byte; out_pop takes it. out_run_last marks the last byte of one input
//   transaction, out_message_done the last payload byte of the message.
// config: cfg_wr_en with cfg_wr_data sets the chunk payload limit (resets to
//   128); write only while idle. zero disables chunk boundaries.
// with the output idle, a taken input transaction is written into the command
//   queue and its first byte is then loaded from there into the output register.
// one input transaction per cycle as long as each yields one byte; a header
//   yields 1 to 18 bytes at the output and a payload byte that opens a new chunk
//   2 to 8, one byte per cycle from the serializer while out_pop keeps up.
// reset: clears the queue, the output register and the message state.
// when the receiver stalls the output byte holds and the four deep command
//   queue (a partly sent command included) fills, then in_full rises.

module rtmp_chunk_framer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_operation,
  input  logic [1:0]  in_format_type,
  input  logic [16:0] in_chunk_stream_id,
  input  logic [31:0] in_timestamp,
  input  logic        in_extended,
  input  logic [23:0] in_message_length,
  input  logic [7:0]  in_type_id,
  input  logic [31:0] in_stream_id,
  input  logic [7:0]  in_payload_byte,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_message_done
);

  rcf_pkg::cmd_t push_cmd, head_cmd;
  logic          accept, push, pop, q_full, q_empty;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  rcf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .accept_i          (accept),
    .operation_i       (in_operation),
    .format_type_i     (in_format_type),
    .chunk_stream_id_i (in_chunk_stream_id),
    .timestamp_i       (in_timestamp),
    .extended_i        (in_extended),
    .message_length_i  (in_message_length),
    .type_id_i         (in_type_id),
    .stream_id_i       (in_stream_id),
    .payload_byte_i    (in_payload_byte),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  rcf_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  rcf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_i           (head_cmd),
    .q_empty_i        (q_empty),
    .q_pop_o          (pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_message_done (out_message_done)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] FMT_TYPE2 = 2'd2;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 52;
  localparam int NUM_DIRECTED = 25;

  typedef struct packed {
    logic        op;
    logic [1:0]  fmt;
    logic [16:0] csid;
    logic [31:0] ts;
    logic        ext;
    logic [23:0] len;
    logic [7:0]  tid;
    logic [31:0] sid;
    logic [7:0]  pb;
  } framer_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } stream_byte_t;

  typedef struct packed {
    framer_item_t it;
    logic         typed;
    logic [2:0]   n_exp;
    logic [31:0]  exp_b;
    logic         exp_done;
  } dir_row_t;

  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // stray payload after reset
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'haa}, 1'b1, 3'd0, 32'h0, 1'b0},
    // zero length message
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE0, 17'd5, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h00}, 1'b1, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h55}, 1'b1, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE3, 17'd2, 32'h0, 1'b0, 24'd3, 8'h00, 32'h0,
        8'h00}, 1'b1, 3'd1, 32'hc2000000, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h00}, 1'b1, 3'd1, 32'h00000000, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'hff}, 1'b1, 3'd1, 32'hff000000, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h5a}, 1'b1, 3'd1, 32'h5a000000, 1'b1},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h11}, 1'b1, 3'd0, 32'h0, 1'b0},
    // all-ones timestamp without the extended flag, longest message
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE0, 17'd63, 32'hffffffff, 1'b0, 24'hffffff,
        8'hff, 32'hffffffff, 8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h01}, 1'b1, 3'd1, 32'h01000000, 1'b0},
    // header in the middle of a message
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE1, 17'd64, 32'h12345678, 1'b1, 24'd2, 8'h00,
        32'h0, 8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h80}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h7f}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_HEADER, FMT_TYPE2, 17'd319, 32'hffffffff, 1'b1, 24'd1, 8'h00,
        32'h0, 8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h3c}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE0, 17'd320, 32'h0, 1'b0, 24'd1, 8'h14,
        32'h01020304, 8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'hc3}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE1, 17'd65599, 32'h00abcdef, 1'b0, 24'd1,
        8'h09, 32'h0, 8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h96}, 1'b0, 3'd0, 32'h0, 1'b0},
    // id above the three byte range
    '{'{rcf_pkg::OP_HEADER, FMT_TYPE2, 17'h1ffff, 32'h0, 1'b1, 24'd1, 8'h00, 32'h0,
        8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h69}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd1, 8'h00, 32'h0,
        8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    // type 3 first chunk with extended timestamp
    '{'{rcf_pkg::OP_HEADER, rcf_pkg::FMT_TYPE3, 17'd1, 32'hdeadbeef, 1'b1, 24'd1, 8'h00,
        32'h0, 8'h00}, 1'b0, 3'd0, 32'h0, 1'b0},
    '{'{rcf_pkg::OP_PAYLOAD, rcf_pkg::FMT_TYPE0, 17'd0, 32'h0, 1'b0, 24'd0, 8'h00, 32'h0,
        8'hff}, 1'b0, 3'd0, 32'h0, 1'b0}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_operation = 1'b0;
  logic [1:0]  in_format_type = '0;
  logic [16:0] in_chunk_stream_id = '0;
  logic [31:0] in_timestamp = '0;
  logic        in_extended = 1'b0;
  logic [23:0] in_message_length = '0;
  logic [7:0]  in_type_id = '0;
  logic [31:0] in_stream_id = '0;
  logic [7:0]  in_payload_byte = '0;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_message_done;

  rtmp_chunk_framer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_operation      (in_operation),
    .in_format_type    (in_format_type),
    .in_chunk_stream_id(in_chunk_stream_id),
    .in_timestamp      (in_timestamp),
    .in_extended       (in_extended),
    .in_message_length (in_message_length),
    .in_type_id        (in_type_id),
    .in_stream_id      (in_stream_id),
    .in_payload_byte   (in_payload_byte),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_message_done  (out_message_done)
  );

  stream_byte_t pending_bytes [$];
  stream_byte_t frame_scratch [$];

  logic [23:0] chunk_limit = rcf_pkg::CHUNK_CAP_RESET;
  logic [23:0] chunk_fill = '0;
  logic [23:0] bytes_owed = '0;
  logic [16:0] held_csid = '0;
  logic        held_ext = 1'b0;
  logic [31:0] held_ext_ts = '0;

  int mismatches = 0;
  int bytes_seen = 0;
  int msg_left = 0;
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void emit(input logic [7:0] b, input logic done);
    stream_byte_t e;
    e.data = b;
    e.last = 1'b0;
    e.done = done;
    frame_scratch.push_back(e);
  endfunction

  function automatic void emit_basic(input logic [1:0] fmt, input logic [16:0] id);
    logic [7:0]  first;
    logic [15:0] wide;
    first = {fmt, 6'b0};
    if (id < rcf_pkg::LONG_ID_BASE) begin
      emit(first | {2'b0, id[5:0]}, 1'b0);
    end else if (id < rcf_pkg::TWO_BYTE_LIMIT) begin
      emit(first, 1'b0);
      emit(8'(id - rcf_pkg::LONG_ID_BASE), 1'b0);
    end else begin
      wide = 16'(id - rcf_pkg::LONG_ID_BASE);
      emit(first | 8'h01, 1'b0);
      emit(wide[7:0], 1'b0);
      emit(wide[15:8], 1'b0);
    end
  endfunction

  function automatic void emit_ts32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) emit(v[8*i +: 8], 1'b0);
  endfunction

  function automatic void frame_header(input framer_item_t it);
    logic [23:0] ts24;
    held_csid = it.csid;
    held_ext = it.ext;
    held_ext_ts = it.ts;
    bytes_owed = it.len;
    chunk_fill = '0;
    if (it.len == '0) return;
    emit_basic(it.fmt, it.csid);
    if (it.fmt != rcf_pkg::FMT_TYPE3) begin
      ts24 = it.ext ? rcf_pkg::EXT_TS_MARK : it.ts[23:0];
      for (int i = 2; i >= 0; i--) emit(ts24[8*i +: 8], 1'b0);
    end
    if (it.fmt == rcf_pkg::FMT_TYPE0 || it.fmt == rcf_pkg::FMT_TYPE1) begin
      for (int i = 2; i >= 0; i--) emit(it.len[8*i +: 8], 1'b0);
      emit(it.tid, 1'b0);
    end
    if (it.fmt == rcf_pkg::FMT_TYPE0) begin
      for (int i = 0; i < 4; i++) emit(it.sid[8*i +: 8], 1'b0);
    end
    if (it.ext) emit_ts32(it.ts);
  endfunction

  function automatic void frame_payload(input logic [7:0] pb);
    if (bytes_owed == '0) return;
    if (chunk_limit != '0 && chunk_fill >= chunk_limit) begin
      emit_basic(rcf_pkg::FMT_TYPE3, held_csid);
      if (held_ext) emit_ts32(held_ext_ts);
      chunk_fill = '0;
    end
    bytes_owed = bytes_owed - 24'd1;
    chunk_fill = chunk_fill + 24'd1;
    emit(pb, bytes_owed == '0);
  endfunction

  function automatic void frame_item(input framer_item_t it);
    stream_byte_t e;
    frame_scratch.delete();
    if (it.op == rcf_pkg::OP_HEADER) frame_header(it);
    else frame_payload(it.pb);
    if (frame_scratch.size() > 0) begin
      e = frame_scratch.pop_back();
      e.last = 1'b1;
      frame_scratch.push_back(e);
    end
  endfunction

  function automatic void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic void check_byte(input logic [7:0] b, input logic rl, input logic md);
    stream_byte_t e;
    if (pending_bytes.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %02h run_last %0b message_done %0b",
                              b, rl, md));
      return;
    end
    e = pending_bytes.pop_front();
    if (b !== e.data)
      flag_mismatch($sformatf("byte %0d out_byte: expected %02h actual %02h",
                              bytes_seen, e.data, b));
    if (rl !== e.last)
      flag_mismatch($sformatf("byte %0d run_last: expected %0b actual %0b",
                              bytes_seen, e.last, rl));
    if (md !== e.done)
      flag_mismatch($sformatf("byte %0d message_done: expected %0b actual %0b",
                              bytes_seen, e.done, md));
  endfunction

  function automatic framer_item_t noise_item();
    framer_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.fmt = 2'($urandom_range(0, 3));
    it.csid = 17'($urandom);
    it.ts = $urandom;
    it.ext = 1'($urandom_range(0, 1));
    it.len = 24'($urandom);
    it.tid = 8'($urandom);
    it.sid = $urandom;
    it.pb = 8'($urandom);
    return it;
  endfunction

  function automatic framer_item_t random_header(output int plan);
    framer_item_t it;
    int pick;
    it = noise_item();
    it.op = rcf_pkg::OP_HEADER;
    pick = $urandom_range(0, 99);
    if (pick < 40) it.csid = 17'($urandom_range(2, 63));
    else if (pick < 65) it.csid = 17'($urandom_range(64, 319));
    else if (pick < 90) it.csid = 17'($urandom_range(320, 65599));
    it.ext = ($urandom_range(0, 9) < 3);
    if (!it.ext && $urandom_range(0, 9) == 0) it.ts[23:0] = rcf_pkg::EXT_TS_MARK;
    pick = $urandom_range(0, 99);
    if (pick < 8) it.len = '0;
    else if (pick < 86) it.len = 24'($urandom_range(1, 24));
    else if (pick < 95) it.len = 24'($urandom_range(25, 200));
    if (pick >= 95) plan = $urandom_range(1, 40);
    else if (it.len > 1 && $urandom_range(0, 9) == 0) plan = $urandom_range(1, it.len - 1);
    else plan = it.len;
    return it;
  endfunction

  task automatic push_item(input framer_item_t it, input int gap);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_operation <= it.op;
    in_format_type <= it.fmt;
    in_chunk_stream_id <= it.csid;
    in_timestamp <= it.ts;
    in_extended <= it.ext;
    in_message_length <= it.len;
    in_type_id <= it.tid;
    in_stream_id <= it.sid;
    in_payload_byte <= it.pb;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
  endtask

  task automatic offer(input framer_item_t it, input int gap);
    push_item(it, gap);
    frame_item(it);
    foreach (frame_scratch[i]) pending_bytes.push_back(frame_scratch[i]);
  endtask

  task automatic quiesce(input int settle);
    in_push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_chunk_cap(input logic [23:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chunk_limit = v;
  endtask

  task automatic run_phase(input int n_items, input bit calm);
    framer_item_t it;
    int sent;
    int gap;
    sent = 0;
    while (sent < n_items) begin
      gap = calm ? 0 : $urandom_range(0, 12);
      if (msg_left == 0 && $urandom_range(0, 7) == 0) begin
        it = noise_item();
        it.op = rcf_pkg::OP_PAYLOAD;
      end else if (msg_left == 0 || $urandom_range(0, 99) < 3) begin
        it = random_header(msg_left);
        sent++;
      end else begin
        it = noise_item();
        it.op = rcf_pkg::OP_PAYLOAD;
        msg_left--;
        sent++;
      end
      offer(it, gap);
    end
  endtask

  initial begin : result_drain
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end else if ((bytes_seen / 40) % 3 == 0) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 12);
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty !== 1'b0) @(posedge clk);
      check_byte(out_byte, out_run_last, out_message_done);
      bytes_seen++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected",
             cycles, pending_bytes.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    dir_row_t     row;
    stream_byte_t e;
    logic [23:0]  size_pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED[i];
      push_item(row.it, $urandom_range(0, 12));
      frame_item(row.it);
      if (row.typed) begin
        for (int k = 0; k < int'(row.n_exp); k++) begin
          e.data = row.exp_b[31 - 8*k -: 8];
          e.last = (k == int'(row.n_exp) - 1);
          e.done = e.last & row.exp_done;
          pending_bytes.push_back(e);
        end
      end else begin
        foreach (frame_scratch[j]) pending_bytes.push_back(frame_scratch[j]);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: size_pick = 24'd1;
        1: size_pick = 24'd3;
        2: size_pick = 24'd0;
        3: size_pick = 24'hffffff;
        4: size_pick = 24'($urandom_range(1, 16));
        5: size_pick = 24'd2;
        6: size_pick = rcf_pkg::CHUNK_CAP_RESET;
        default: size_pick = 24'($urandom_range(1, 6));
      endcase
      quiesce(SETTLE_CYCLES);
      write_chunk_cap(size_pick);
      if (p == 2) hold_off_req = 1'b1;
      run_phase(PHASE_ITEMS, p == 2 || p % 3 == 1);
    end

    quiesce(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
